// ----- hdl/v3alu_pkg.sv -----
// Package for the Q16.16 vector unit: beat structs, op codes and the
// clamp helper. No dependencies.
package v3alu_pkg;

    localparam int NLANE = 3;
    localparam int NMUL  = 16;

    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_SCALE = 4'd2;
    localparam logic [3:0] OP_MULE  = 4'd3;
    localparam logic [3:0] OP_DIVS  = 4'd4;
    localparam logic [3:0] OP_DIVE  = 4'd5;
    localparam logic [3:0] OP_DOT   = 4'd6;
    localparam logic [3:0] OP_CROSS = 4'd7;
    localparam logic [3:0] OP_XFORM = 4'd8;

    localparam logic [3:0] CFG_NREG = 4'd8;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [3:0]         op;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] a_w;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] scalar;
    } t_vin;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
        logic               divide_by_zero;
        logic               saturated;
    } t_vout;

    typedef struct packed {
        logic signed [31:0] val;
        logic               sat;
    } t_clamp;

    function automatic t_clamp clamp32(input logic signed [65:0] v);
        t_clamp c;
        c.sat = 1'b1;
        if (v > 66'(S32_MAX)) begin
            c.val = S32_MAX;
        end else if (v < 66'(S32_MIN)) begin
            c.val = S32_MIN;
        end else begin
            c.val = v[31:0];
            c.sat = 1'b0;
        end
        return c;
    endfunction

endpackage

// ----- hdl/vec3_alu_with_matrix_transform.sv -----
// Vector unit top level: operand select, 16 multiplier lanes, adder tree,
// clamp and three pipelined restoring dividers. Depends on v3alu_pkg.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------------
//   input    | i_in_valid / o_in_stall   | i_in_data  (t_vin)
//   output   | o_out_valid / i_out_stall | o_out_data (t_vout)
//   config   | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// One beat enters per cycle while the output is not stalled; the divider
// resolves one quotient bit per stage over 32 stages.
// All stages advance together; a stall on the output freezes the whole
// pipeline and raises o_in_stall. Bubbles inside stay in place during a stall.
// Synchronous active-low reset clears valid bits and the matrix.
module vec3_alu_with_matrix_transform
    import v3alu_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_vin        i_in_data,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_vout       o_out_data,
    input  logic        i_out_stall,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);

    localparam int QB = 32;
    localparam int SH = 32 - FRAC_BITS;

    logic en;

    logic [63:0] r_mat [8];

    logic r1_vld;
    t_vin r1_item;

    logic                r2_vld;
    logic [3:0]          r2_op;
    logic signed [32:0]  r2_as   [NLANE];
    logic signed [31:0]  r2_ma   [NMUL];
    logic signed [31:0]  r2_mb   [NMUL];
    logic [31:0]         r2_nabs [NLANE];
    logic [31:0]         r2_dabs [NLANE];
    logic                r2_nneg [NLANE];
    logic                r2_qneg [NLANE];
    logic                r2_dz   [NLANE];

    logic [3:0]          r3_op;
    logic signed [32:0]  r3_as [NLANE];
    logic signed [63:0]  r3_p  [NMUL];

    logic signed [65:0]  r4_sum [4];

    logic        r_vld   [0:QB];
    logic        r_isdiv [0:QB];
    logic [31:0] r_rem   [0:QB][NLANE];
    logic [31:0] r_low   [0:QB][NLANE];
    logic [31:0] r_quo   [0:QB][NLANE];
    logic [31:0] r_den   [0:QB][NLANE];
    logic        r_nneg  [0:QB][NLANE];
    logic        r_qneg  [0:QB][NLANE];
    logic        r_dz    [0:QB][NLANE];
    logic        r_ovf   [0:QB][NLANE];
    t_vout       r_res   [2:QB];

    logic  r_ovld;
    t_vout r_out;

    logic signed [31:0] a_v [4];
    logic signed [31:0] b_v [NLANE];
    logic signed [31:0] mat [4][4];
    logic signed [32:0] n_as   [NLANE];
    logic signed [31:0] n_ma   [NMUL];
    logic signed [31:0] n_mb   [NMUL];
    logic [31:0]        n_nabs [NLANE];
    logic [31:0]        n_dabs [NLANE];
    logic               n_nneg [NLANE];
    logic               n_qneg [NLANE];
    logic               n_dz   [NLANE];
    logic signed [31:0] dvd    [NLANE];
    logic signed [31:0] dvs    [NLANE];
    logic signed [63:0] n_p    [NMUL];
    logic [31:0]        n_hi   [NLANE];
    logic               n_ovf  [NLANE];
    logic signed [65:0] n_sum  [4];
    t_vout              n_res;
    logic [31:0]        n_rem  [1:QB][NLANE];
    logic [31:0]        n_quo  [1:QB][NLANE];
    t_vout              n_out;
    logic [31:0]        fin    [NLANE];
    logic               fin_sat[NLANE];

    assign en          = !(r_ovld && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_ovld;
    assign o_out_data  = r_out;

    // Matrix and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) r_mat[i] <= '0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            for (int j = 0; j <= QB; j++) r_vld[j] <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx < CFG_NREG) begin
                r_mat[i_cfg_idx[2:0]] <= i_cfg_data;
            end
            if (en) begin
                r1_vld   <= i_in_valid;
                r2_vld   <= r1_vld;
                r_vld[0] <= r2_vld;
                for (int j = 1; j <= QB; j++) r_vld[j] <= r_vld[j-1];
                r_ovld   <= r_vld[QB];
            end
        end
    end

    // Stage 2: operand select, abs values, add/sub
    always_comb begin
        a_v[0] = r1_item.a_x;
        a_v[1] = r1_item.a_y;
        a_v[2] = r1_item.a_z;
        a_v[3] = r1_item.a_w;
        b_v[0] = r1_item.b_x;
        b_v[1] = r1_item.b_y;
        b_v[2] = r1_item.b_z;
        for (int i = 0; i < 4; i++) begin
            for (int c = 0; c < 4; c++) begin
                mat[i][c] = c[0] ? r_mat[2*i + c/2][63:32] : r_mat[2*i + c/2][31:0];
            end
        end
        for (int l = 0; l < NLANE; l++) begin
            n_as[l] = (r1_item.op == OP_SUB) ? 33'(a_v[l]) - 33'(b_v[l])
                                             : 33'(a_v[l]) + 33'(b_v[l]);
            dvd[l]    = a_v[l];
            dvs[l]    = (r1_item.op == OP_DIVS) ? r1_item.scalar : b_v[l];
            n_nneg[l] = dvd[l][31];
            n_qneg[l] = dvd[l][31] ^ dvs[l][31];
            n_dz[l]   = (dvs[l] == '0);
            n_nabs[l] = dvd[l][31] ? 32'(-dvd[l]) : 32'(dvd[l]);
            n_dabs[l] = dvs[l][31] ? 32'(-dvs[l]) : 32'(dvs[l]);
        end
        for (int m = 0; m < NMUL; m++) begin
            n_ma[m] = '0;
            n_mb[m] = '0;
        end
        case (r1_item.op)
            OP_SCALE: begin
                for (int l = 0; l < NLANE; l++) begin
                    n_ma[l] = a_v[l];
                    n_mb[l] = r1_item.scalar;
                end
            end
            OP_MULE, OP_DOT: begin
                for (int l = 0; l < NLANE; l++) begin
                    n_ma[l] = a_v[l];
                    n_mb[l] = b_v[l];
                end
            end
            OP_CROSS: begin
                n_ma[0] = a_v[1]; n_mb[0] = b_v[2];
                n_ma[1] = a_v[2]; n_mb[1] = b_v[1];
                n_ma[2] = a_v[2]; n_mb[2] = b_v[0];
                n_ma[3] = a_v[0]; n_mb[3] = b_v[2];
                n_ma[4] = a_v[0]; n_mb[4] = b_v[1];
                n_ma[5] = a_v[1]; n_mb[5] = b_v[0];
            end
            OP_XFORM: begin
                for (int c = 0; c < 4; c++) begin
                    for (int i = 0; i < 4; i++) begin
                        n_ma[4*c + i] = a_v[i];
                        n_mb[4*c + i] = mat[i][c];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Stage 3: products, divider setup
    always_comb begin
        for (int m = 0; m < NMUL; m++) begin
            n_p[m] = (r2_ma[m] * r2_mb[m]) >>> FRAC_BITS;
        end
        for (int l = 0; l < NLANE; l++) begin
            n_hi[l]  = r2_nabs[l] >> SH;
            n_ovf[l] = !r2_dz[l] && (n_hi[l] >= r2_dabs[l]);
        end
    end

    // Stage 4: sums
    always_comb begin
        for (int c = 0; c < 4; c++) n_sum[c] = '0;
        case (r3_op)
            OP_ADD, OP_SUB: begin
                for (int l = 0; l < NLANE; l++) n_sum[l] = 66'(r3_as[l]);
            end
            OP_SCALE, OP_MULE: begin
                for (int l = 0; l < NLANE; l++) n_sum[l] = 66'(r3_p[l]);
            end
            OP_DOT: begin
                n_sum[0] = 66'(r3_p[0]) + 66'(r3_p[1]) + 66'(r3_p[2]);
            end
            OP_CROSS: begin
                n_sum[0] = 66'(r3_p[0]) - 66'(r3_p[1]);
                n_sum[1] = 66'(r3_p[2]) - 66'(r3_p[3]);
                n_sum[2] = 66'(r3_p[4]) - 66'(r3_p[5]);
            end
            OP_XFORM: begin
                for (int c = 0; c < 4; c++) begin
                    n_sum[c] = 66'(r3_p[4*c]) + 66'(r3_p[4*c+1])
                             + 66'(r3_p[4*c+2]) + 66'(r3_p[4*c+3]);
                end
            end
            default: begin
            end
        endcase
    end

    // Stage 5: clamp
    always_comb begin
        t_clamp cx, cy, cz, cw;
        cx = clamp32(r4_sum[0]);
        cy = clamp32(r4_sum[1]);
        cz = clamp32(r4_sum[2]);
        cw = clamp32(r4_sum[3]);
        n_res.out_x          = cx.val;
        n_res.out_y          = cy.val;
        n_res.out_z          = cz.val;
        n_res.out_w          = cw.val;
        n_res.divide_by_zero = 1'b0;
        n_res.saturated      = cx.sat | cy.sat | cz.sat | cw.sat;
    end

    // Divider: one restoring step per stage
    always_comb begin
        logic [32:0] t;
        logic        ge;
        for (int j = 0; j < QB; j++) begin
            for (int l = 0; l < NLANE; l++) begin
                t  = {r_rem[j][l], r_low[j][l][31]};
                ge = (t >= {1'b0, r_den[j][l]});
                n_rem[j+1][l] = ge ? 32'(t - {1'b0, r_den[j][l]}) : t[31:0];
                n_quo[j+1][l] = {r_quo[j][l][30:0], ge};
            end
        end
    end

    // Sign, clamp and merge
    always_comb begin
        logic [31:0] q;
        for (int l = 0; l < NLANE; l++) begin
            q          = r_quo[QB][l];
            fin_sat[l] = 1'b1;
            if (r_dz[QB][l]) begin
                fin[l] = r_nneg[QB][l] ? S32_MIN : S32_MAX;
            end else if (r_ovf[QB][l]) begin
                fin[l] = r_qneg[QB][l] ? S32_MIN : S32_MAX;
            end else if (r_qneg[QB][l]) begin
                if (q > 32'h8000_0000) begin
                    fin[l] = S32_MIN;
                end else begin
                    fin[l]     = -q;
                    fin_sat[l] = 1'b0;
                end
            end else if (q[31]) begin
                fin[l] = S32_MAX;
            end else begin
                fin[l]     = q;
                fin_sat[l] = 1'b0;
            end
        end
        if (r_isdiv[QB]) begin
            n_out.out_x          = fin[0];
            n_out.out_y          = fin[1];
            n_out.out_z          = fin[2];
            n_out.out_w          = '0;
            n_out.divide_by_zero = r_dz[QB][0] | r_dz[QB][1] | r_dz[QB][2];
            n_out.saturated      = fin_sat[0] | fin_sat[1] | fin_sat[2];
        end else begin
            n_out = r_res[QB];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_item <= i_in_data;

            r2_op <= r1_item.op;
            for (int l = 0; l < NLANE; l++) begin
                r2_as[l]   <= n_as[l];
                r2_nabs[l] <= n_nabs[l];
                r2_dabs[l] <= n_dabs[l];
                r2_nneg[l] <= n_nneg[l];
                r2_qneg[l] <= n_qneg[l];
                r2_dz[l]   <= n_dz[l];
            end
            for (int m = 0; m < NMUL; m++) begin
                r2_ma[m] <= n_ma[m];
                r2_mb[m] <= n_mb[m];
            end

            r3_op <= r2_op;
            for (int l = 0; l < NLANE; l++) r3_as[l] <= r2_as[l];
            for (int m = 0; m < NMUL; m++) r3_p[m] <= n_p[m];
            r_isdiv[0] <= (r2_op inside {OP_DIVS, OP_DIVE});
            for (int l = 0; l < NLANE; l++) begin
                r_rem[0][l]  <= (n_ovf[l] || r2_dz[l]) ? '0 : n_hi[l];
                r_low[0][l]  <= r2_nabs[l] << FRAC_BITS;
                r_quo[0][l]  <= '0;
                r_den[0][l]  <= r2_dabs[l];
                r_nneg[0][l] <= r2_nneg[l];
                r_qneg[0][l] <= r2_qneg[l];
                r_dz[0][l]   <= r2_dz[l];
                r_ovf[0][l]  <= n_ovf[l];
            end

            for (int c = 0; c < 4; c++) r4_sum[c] <= n_sum[c];
            r_res[2] <= n_res;
            for (int j = 3; j <= QB; j++) r_res[j] <= r_res[j-1];

            // advance divider stages
            for (int j = 1; j <= QB; j++) begin
                r_isdiv[j] <= r_isdiv[j-1];
                for (int l = 0; l < NLANE; l++) begin
                    r_rem[j][l]  <= n_rem[j][l];
                    r_quo[j][l]  <= n_quo[j][l];
                    r_low[j][l]  <= {r_low[j-1][l][30:0], 1'b0};
                    r_den[j][l]  <= r_den[j-1][l];
                    r_nneg[j][l] <= r_nneg[j-1][l];
                    r_qneg[j][l] <= r_qneg[j-1][l];
                    r_dz[j][l]   <= r_dz[j-1][l];
                    r_ovf[j][l]  <= r_ovf[j-1][l];
                end
            end

            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    // Divide by zero always comes with saturation
    a_dz_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.divide_by_zero |-> o_out_data.saturated)
        else $error("divide_by_zero without saturated");

    // Division beats carry no w component
    a_div_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[QB] && r_isdiv[QB] && en |=> o_out_data.out_w == '0)
        else $error("division beat with nonzero w");

    // Non-division beats never flag divide by zero
    a_nodiv_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[QB] && !r_isdiv[QB] && en |=> !o_out_data.divide_by_zero)
        else $error("divide_by_zero on non-division beat");

    // The input side stalls only behind a held output beat
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");
`endif

endmodule
